// ----- rtl/core/cbg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circuit breaker gate package
// Shared types and constants for the three-state circuit breaker.
// ----------------------------------------------------------------------------
package cbg_pkg;

    localparam int TIME_W   = 64;
    localparam int STREAK_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        BRK_CLOSED    = 2'd0,
        BRK_OPEN      = 2'd1,
        BRK_HALF_OPEN = 2'd2
    } brk_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIP_THRESHOLD = 2'd0,
        CFG_COOLDOWN_TIME  = 2'd1
    } cfg_index_t;

    localparam logic CMD_ALLOW  = 1'b0;
    localparam logic CMD_RECORD = 1'b1;

    localparam logic [STREAK_W-1:0] STREAK_MAX    = {STREAK_W{1'b1}};
    localparam logic [STREAK_W-1:0] THRESHOLD_RST = STREAK_W'(1);

endpackage

// ----- rtl/core/cbg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circuit breaker gate channel interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface cbg_req_if
    import cbg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic              outcome_ok;
    logic [TIME_W-1:0] timestamp;

    modport source (output valid, output command, output outcome_ok, output timestamp,
                    input ready);
    modport sink   (input valid, input command, input outcome_ok, input timestamp,
                    output ready);
endinterface

interface cbg_rsp_if;
    logic       valid;
    logic       ready;
    logic       allowed;
    logic [1:0] breaker_state;

    modport source (output valid, output allowed, output breaker_state, input ready);
    modport sink   (input valid, input allowed, input breaker_state, output ready);
endinterface

interface cbg_cfg_if
    import cbg_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TIME_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/circuit_breaker_gate_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circuit breaker gate core
// Three-state circuit breaker (closed, open, half-open) that grants or
// refuses call requests and tracks recorded call outcomes.
// ----------------------------------------------------------------------------
// Each request on the req channel either asks permission for a call or
// records a call's outcome, and carries the caller's 64-bit timestamp.
// Every request yields exactly one response on the rsp channel with the
// grant flag and the breaker state after the request.
// The cfg channel writes the trip threshold (index 0) and the cooldown time
// (index 1); it is always ready and other indexes are ignored.
// A request is captured in an input register and then evaluated into the
// response register, which drives the response. One request is accepted
// every cycle while the receiver takes each response.
// The breaker state is updated as each request moves into the response
// register, so back-to-back requests see the state left by the one before.
// When the receiver stalls, the response register holds and the input
// register still takes one more request; further requests wait.
// Reset closes the breaker, clears the failure streak and trip time, sets
// the threshold to one and the cooldown to zero.
// ----------------------------------------------------------------------------
module circuit_breaker_gate_core
    import cbg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cbg_req_if.sink    req,
    cbg_rsp_if.source  rsp,
    cbg_cfg_if.sink    cfg
);

    logic                in_valid_reg;
    logic                in_command_reg;
    logic                in_ok_reg;
    logic [TIME_W-1:0]   in_time_reg;

    logic                out_valid_reg;
    logic                out_allowed_reg;
    logic                out_allowed_next;

    brk_state_t          state_reg;
    brk_state_t          state_next;
    logic [STREAK_W-1:0] streak_reg;
    logic [STREAK_W-1:0] streak_next;
    logic [TIME_W-1:0]   tripped_reg;
    logic [TIME_W-1:0]   tripped_next;

    logic [STREAK_W-1:0] threshold_reg;
    logic [TIME_W-1:0]   cooldown_reg;

    logic                advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.allowed       = out_allowed_reg;
    assign rsp.breaker_state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            cooldown_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TRIP_THRESHOLD: threshold_reg <= cfg.data[STREAK_W-1:0];
                CFG_COOLDOWN_TIME:  cooldown_reg  <= cfg.data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_command_reg <= req.command;
            in_ok_reg      <= req.outcome_ok;
            in_time_reg    <= req.timestamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_allowed_reg <= out_allowed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BRK_CLOSED;
            streak_reg  <= '0;
            tripped_reg <= '0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            streak_reg  <= streak_next;
            tripped_reg <= tripped_next;
        end
    end

    always_comb
    begin
        logic [TIME_W-1:0]   elapsed;
        logic [STREAK_W-1:0] streak_inc;
        logic [STREAK_W-1:0] threshold_eff;

        elapsed       = in_time_reg - tripped_reg;
        streak_inc    = (streak_reg == STREAK_MAX) ? streak_reg : streak_reg + 1'b1;
        threshold_eff = (threshold_reg == '0) ? THRESHOLD_RST : threshold_reg;

        state_next       = state_reg;
        streak_next      = streak_reg;
        tripped_next     = tripped_reg;
        out_allowed_next = 1'b0;

        if (in_command_reg == CMD_ALLOW)
        begin
            case (state_reg)
                BRK_OPEN:
                begin
                    if (elapsed >= cooldown_reg)
                    begin
                        state_next       = BRK_HALF_OPEN;
                        out_allowed_next = 1'b1;
                    end
                end
                default:
                begin
                    out_allowed_next = 1'b1;
                end
            endcase
        end
        else if (in_ok_reg)
        begin
            state_next  = BRK_CLOSED;
            streak_next = '0;
        end
        else
        begin
            case (state_reg)
                BRK_HALF_OPEN:
                begin
                    state_next   = BRK_OPEN;
                    tripped_next = in_time_reg;
                end
                default:
                begin
                    streak_next = streak_inc;
                    if (streak_inc >= threshold_eff)
                    begin
                        state_next   = BRK_OPEN;
                        tripped_next = in_time_reg;
                    end
                end
            endcase
        end
    end

endmodule
